// File: hdl/one_wire_bus_master_macros.svh
// Assertion helpers for the RTL top level.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Checked on every clock edge outside reset.
`define OWBM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define OWBM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hdl/owbm_pkg.sv
package owbm_pkg;

   localparam int TIMER_W    = 10;
   localparam int BYTE_W     = 8;
   localparam int MODE_W     = 2;
   localparam int PHASE_W    = 4;
   localparam int BIT_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam int READ_TAIL_TICKS_DEF = 60;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRES_WAIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRES_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_RECOVER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_SHORT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_LONG    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_READ_LOW      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_READ_SAMPLE   = 3'd7;

   // register defaults
   localparam logic [TIMER_W-1:0] RESET_LOW_DEF     = 10'd750;
   localparam logic [TIMER_W-1:0] PRES_WAIT_DEF     = 10'd30;
   localparam logic [TIMER_W-1:0] PRES_TIMEOUT_DEF  = 10'd303;
   localparam logic [TIMER_W-1:0] RESET_RECOVER_DEF = 10'd480;
   localparam logic [BYTE_W-1:0]  WRITE_SHORT_DEF   = 8'd5;
   localparam logic [BYTE_W-1:0]  WRITE_LONG_DEF    = 8'd75;
   localparam logic [BYTE_W-1:0]  READ_LOW_DEF      = 8'd3;
   localparam logic [BYTE_W-1:0]  READ_SAMPLE_DEF   = 8'd10;

   // sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd2;
   localparam logic [PHASE_W-1:0] PH_RST_POLL = 4'd3;
   localparam logic [PHASE_W-1:0] PH_RST_REC  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_WR_LOW   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_WR_HIGH  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd7;
   localparam logic [PHASE_W-1:0] PH_RD_WAIT  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_RD_TAIL  = 4'd9;

   typedef struct packed {
      logic [TIMER_W-1:0] reset_low;
      logic [TIMER_W-1:0] pres_wait;
      logic [TIMER_W-1:0] pres_timeout;
      logic [TIMER_W-1:0] reset_recover;
      logic [BYTE_W-1:0]  write_short;
      logic [BYTE_W-1:0]  write_long;
      logic [BYTE_W-1:0]  read_low;
      logic [BYTE_W-1:0]  read_sample;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TIMER_W-1:0] timer;
      logic [BIT_W-1:0]   bit_idx;
      logic [BYTE_W-1:0]  shift;
   } state_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence_found;
      logic              presence_error;
      logic [BYTE_W-1:0] read_byte;
      logic              command_rejected;
   } result_type;

   // a programmed duration of zero counts as one tick
   function automatic logic [TIMER_W-1:0] nz_ticks(input logic [TIMER_W-1:0] v);
      return (v == '0) ? TIMER_W'(1) : v;
   endfunction

endpackage

// File: hdl/owbm_ifs.sv
interface owbm_req_if import owbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] write_data;
   logic              bus_level;

   modport source (output valid, mode, write_data, bus_level, input ready);
   modport sink   (input valid, mode, write_data, bus_level, output ready);
endinterface

interface owbm_rsp_if import owbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              drive_low;
   logic              busy_res;
   logic              done_res;
   logic              presence_found;
   logic              presence_error;
   logic [BYTE_W-1:0] read_byte;
   logic              command_rejected;

   modport source (output valid, drive_low, busy_res, done_res, presence_found,
                   presence_error, read_byte, command_rejected, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, presence_found,
                   presence_error, read_byte, command_rejected, output ready);
endinterface

interface owbm_csr_if import owbm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/owbm_step.sv
// Next-state and result logic for one microsecond tick.
module owbm_step import owbm_pkg::*; #(
   parameter int READ_TAIL_TICKS = READ_TAIL_TICKS_DEF
) (
   input  state_type         cur_st,
   input  cfg_type           cfg,
   input  logic [MODE_W-1:0] mode,
   input  logic [BYTE_W-1:0] write_data,
   input  logic              bus_level,
   output state_type         nxt_st,
   output result_type        res
);

   localparam logic [TIMER_W-1:0] TAIL_TICKS = TIMER_W'(READ_TAIL_TICKS);

   logic [TIMER_W-1:0] d_reset_low, d_pres_wait, d_pres_timeout, d_reset_recover;
   logic [TIMER_W-1:0] d_write_short, d_write_long, d_read_low, d_read_sample;

   // effective durations
   assign d_reset_low     = nz_ticks(cfg.reset_low);
   assign d_pres_wait     = nz_ticks(cfg.pres_wait);
   assign d_pres_timeout  = nz_ticks(cfg.pres_timeout);
   assign d_reset_recover = nz_ticks(cfg.reset_recover);
   assign d_write_short   = nz_ticks(TIMER_W'(cfg.write_short));
   assign d_write_long    = nz_ticks(TIMER_W'(cfg.write_long));
   assign d_read_low      = nz_ticks(TIMER_W'(cfg.read_low));
   assign d_read_sample   = nz_ticks(TIMER_W'(cfg.read_sample));

   always_comb begin
      state_type          st;
      logic [TIMER_W-1:0] tdec;

      st  = cur_st;
      res = '0;

      // command start or reject
      if (st.phase != PH_IDLE) begin
         res.command_rejected = (mode != MODE_TICK);
      end else begin
         st.bit_idx = '0;
         unique case (mode)
            MODE_TICK: begin
               st.bit_idx = cur_st.bit_idx;
            end
            MODE_RESET: begin
               st.phase = PH_RST_LOW;
               st.timer = d_reset_low;
            end
            MODE_WRITE: begin
               st.shift = write_data;
               st.phase = PH_WR_LOW;
               st.timer = write_data[0] ? d_write_short : d_write_long;
            end
            MODE_READ: begin
               st.shift = '0;
               st.phase = PH_RD_LOW;
               st.timer = d_read_low;
            end
         endcase
      end

      tdec = st.timer - TIMER_W'(1);

      // phase sequencer
      unique case (st.phase)
         PH_IDLE: begin
         end
         PH_RST_LOW: begin
            res.drive_low = 1'b1;
            if (tdec == '0) begin
               st.phase = PH_RST_WAIT;
               st.timer = d_pres_wait;
            end else begin
               st.timer = tdec;
            end
         end
         PH_RST_WAIT: begin
            if (tdec == '0) begin
               st.phase = PH_RST_POLL;
               st.timer = d_pres_timeout;
            end else begin
               st.timer = tdec;
            end
         end
         PH_RST_POLL: begin
            if (!bus_level) begin
               st.phase = PH_RST_REC;
               st.timer = d_reset_recover;
            end else begin
               st.timer = tdec;
               if (tdec == '0) begin
                  st.phase           = PH_IDLE;
                  res.done_res       = 1'b1;
                  res.presence_error = 1'b1;
               end
            end
         end
         PH_RST_REC: begin
            st.timer = tdec;
            if (tdec == '0) begin
               st.phase           = PH_IDLE;
               res.done_res       = 1'b1;
               res.presence_found = 1'b1;
            end
         end
         PH_WR_LOW: begin
            res.drive_low = 1'b1;
            if (tdec == '0) begin
               st.phase = PH_WR_HIGH;
               st.timer = st.shift[0] ? d_write_long : d_write_short;
            end else begin
               st.timer = tdec;
            end
         end
         PH_WR_HIGH: begin
            st.timer = tdec;
            if (tdec == '0) begin
               st.shift = {1'b0, st.shift[BYTE_W-1:1]};
               if (st.bit_idx == '1) begin
                  st.bit_idx   = '0;
                  st.phase     = PH_IDLE;
                  res.done_res = 1'b1;
               end else begin
                  st.bit_idx = st.bit_idx + BIT_W'(1);
                  st.phase   = PH_WR_LOW;
                  st.timer   = st.shift[0] ? d_write_short : d_write_long;
               end
            end
         end
         PH_RD_LOW: begin
            res.drive_low = 1'b1;
            if (tdec == '0) begin
               st.phase = PH_RD_WAIT;
               st.timer = d_read_sample;
            end else begin
               st.timer = tdec;
            end
         end
         PH_RD_WAIT: begin
            if (tdec == '0) begin
               st.phase = PH_RD_TAIL;
               st.timer = TAIL_TICKS;
            end else begin
               st.timer = tdec;
            end
         end
         PH_RD_TAIL: begin
            // sample on the first tail tick
            if (st.timer == TAIL_TICKS) begin
               st.shift = {bus_level, st.shift[BYTE_W-1:1]};
            end
            st.timer = tdec;
            if (tdec == '0) begin
               if (st.bit_idx == '1) begin
                  st.bit_idx    = '0;
                  st.phase      = PH_IDLE;
                  res.done_res  = 1'b1;
                  res.read_byte = st.shift;
               end else begin
                  st.bit_idx = st.bit_idx + BIT_W'(1);
                  st.phase   = PH_RD_LOW;
                  st.timer   = d_read_low;
               end
            end
         end
         default: begin
            st.phase = PH_IDLE;
         end
      endcase

      res.busy_res = (st.phase != PH_IDLE);
      nxt_st       = st;
   end

endmodule

// File: hdl/one_wire_bus_master.sv
// Results: a request's result is registered in the output register when it is
// accepted, or in the skid entry while the output is stalled.
// Throughput: one request (one microsecond tick or command) per cycle while req_ready
// is high; a two-entry output buffer keeps req_ready high while one result is stalled.
// Reset: synchronous; sequencer goes idle, buffer empties, registers take
// their default timings.
`include "one_wire_bus_master_macros.svh"

module one_wire_bus_master import owbm_pkg::*; #(
   parameter int READ_TAIL_TICKS = READ_TAIL_TICKS_DEF
) (
   input logic        clock,
   input logic        reset,
   owbm_req_if.sink   req_bus,
   owbm_rsp_if.source rsp_bus,
   owbm_csr_if.sink   csr_bus
);

   cfg_type    cfg_ff, cfg_in;
   state_type  st_ff, st_in, st_step;
   result_type res_step;
   result_type out_ff, out_in, skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic       req_fire, rsp_fire;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !skid_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = out_valid_ff && rsp_bus.ready;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_RESET_LOW:     cfg_in.reset_low     = csr_bus.data;
            REG_PRES_WAIT:     cfg_in.pres_wait     = csr_bus.data;
            REG_PRES_TIMEOUT:  cfg_in.pres_timeout  = csr_bus.data;
            REG_RESET_RECOVER: cfg_in.reset_recover = csr_bus.data;
            REG_WRITE_SHORT:   cfg_in.write_short   = csr_bus.data[BYTE_W-1:0];
            REG_WRITE_LONG:    cfg_in.write_long    = csr_bus.data[BYTE_W-1:0];
            REG_READ_LOW:      cfg_in.read_low      = csr_bus.data[BYTE_W-1:0];
            REG_READ_SAMPLE:   cfg_in.read_sample   = csr_bus.data[BYTE_W-1:0];
         endcase
      end
   end

   // tick logic
   owbm_step #(
      .READ_TAIL_TICKS (READ_TAIL_TICKS)
   ) u_step (
      .cur_st     (st_ff),
      .cfg        (cfg_ff),
      .mode       (req_bus.mode),
      .write_data (req_bus.write_data),
      .bus_level  (req_bus.bus_level),
      .nxt_st     (st_step),
      .res        (res_step)
   );

   assign st_in = req_fire ? st_step : st_ff;

   // output register plus skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (req_fire) begin
         if (!out_valid_ff || rsp_bus.ready) begin
            out_in       = res_step;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_step;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low     <= RESET_LOW_DEF;
         cfg_ff.pres_wait     <= PRES_WAIT_DEF;
         cfg_ff.pres_timeout  <= PRES_TIMEOUT_DEF;
         cfg_ff.reset_recover <= RESET_RECOVER_DEF;
         cfg_ff.write_short   <= WRITE_SHORT_DEF;
         cfg_ff.write_long    <= WRITE_LONG_DEF;
         cfg_ff.read_low      <= READ_LOW_DEF;
         cfg_ff.read_sample   <= READ_SAMPLE_DEF;
         st_ff                <= '0;
         out_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         st_ff         <= st_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.drive_low        = out_ff.drive_low;
   assign rsp_bus.busy_res         = out_ff.busy_res;
   assign rsp_bus.done_res         = out_ff.done_res;
   assign rsp_bus.presence_found   = out_ff.presence_found;
   assign rsp_bus.presence_error   = out_ff.presence_error;
   assign rsp_bus.read_byte        = out_ff.read_byte;
   assign rsp_bus.command_rejected = out_ff.command_rejected;

   // checks
   `OWBM_ASSERT(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid full, output empty")
   `OWBM_ASSERT(a_drive_while_busy, (out_valid_ff && out_ff.drive_low) |-> out_ff.busy_res,
                "line driven with no command running")
   `OWBM_ASSERT(a_done_not_busy, (out_valid_ff && out_ff.done_res) |-> !out_ff.busy_res,
                "done flagged while still busy")
   `OWBM_ASSERT(a_bit_idx_idle, (st_ff.bit_idx != '0) |-> (st_ff.phase != PH_IDLE),
                "bit index left nonzero in idle")
   `OWBM_ASSERT_RST(a_reset_clears, reset |=> (st_ff.phase == PH_IDLE && !out_valid_ff),
                    "reset did not clear sequencer")

endmodule

// File: bench/tb.sv
module tb;
   import owbm_pkg::*;

   localparam logic [TIMER_W-1:0] TAIL_TICKS = TIMER_W'(READ_TAIL_TICKS_DEF);
   localparam int ITEM_TARGET = 1750;
   localparam int CLOSE_ITEMS = 250;

   // one microsecond tick as offered on the request channel
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] write_data;
      logic              bus_level;
   } tick_req_type;

   // sequencer state after a tick plus what that tick shows on the bus
   typedef struct packed {
      state_type  st;
      result_type res;
   } line_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   owbm_req_if req_bus ();
   owbm_rsp_if rsp_bus ();
   owbm_csr_if csr_bus ();

   one_wire_bus_master #(.READ_TAIL_TICKS(READ_TAIL_TICKS_DEF)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   localparam cfg_type TIMING_DEFAULTS = '{
      reset_low:     RESET_LOW_DEF,
      pres_wait:     PRES_WAIT_DEF,
      pres_timeout:  PRES_TIMEOUT_DEF,
      reset_recover: RESET_RECOVER_DEF,
      write_short:   WRITE_SHORT_DEF,
      write_long:    WRITE_LONG_DEF,
      read_low:      READ_LOW_DEF,
      read_sample:   READ_SAMPLE_DEF
   };

   // line_state/live_cfg follow accepted traffic; plan_* run ahead in the generator
   state_type   line_state = '0;
   cfg_type     live_cfg   = TIMING_DEFAULTS;
   state_type   plan_state = '0;
   cfg_type     plan_cfg   = TIMING_DEFAULTS;

   tick_req_type tick_queue[$];
   result_type   results_due[$];
   tick_req_type next_tick;

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int          bad_count      = 0;
   int          req_odds       = 4;
   int          rsp_odds       = 4;
   int          req_gap        = 0;
   int          rsp_hold       = 0;
   bit          want_long_stall = 1'b0;
   bit          long_stall_done = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // programmed duration, zero counts as one tick
   function automatic logic [TIMER_W-1:0] span(input logic [TIMER_W-1:0] v);
      return v | {{(TIMER_W-1){1'b0}}, (v == '0)};
   endfunction

   // low part of a write slot: short for a one, long for a zero
   function automatic logic [TIMER_W-1:0] bit_low_span(input cfg_type c, input logic b);
      return b ? span(TIMER_W'(c.write_short)) : span(TIMER_W'(c.write_long));
   endfunction

   function automatic cfg_type store_reg(input cfg_type c, input int idx,
                                         input logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_RESET_LOW:     c.reset_low     = d;
         REG_PRES_WAIT:     c.pres_wait     = d;
         REG_PRES_TIMEOUT:  c.pres_timeout  = d;
         REG_RESET_RECOVER: c.reset_recover = d;
         REG_WRITE_SHORT:   c.write_short   = d[BYTE_W-1:0];
         REG_WRITE_LONG:    c.write_long    = d[BYTE_W-1:0];
         REG_READ_LOW:      c.read_low      = d[BYTE_W-1:0];
         REG_READ_SAMPLE:   c.read_sample   = d[BYTE_W-1:0];
         default: ;
      endcase
      return c;
   endfunction

   // one tick of the bus master
   function automatic line_step_type step_master(input state_type s, input cfg_type c,
         input logic [MODE_W-1:0] md, input logic [BYTE_W-1:0] wd, input logic lvl);
      line_step_type o;
      o.res = '0;
      // a command only starts from idle; otherwise it is dropped and flagged
      if (s.phase != PH_IDLE) begin
         o.res.command_rejected = (md != MODE_TICK);
      end else if (md != MODE_TICK) begin
         s.bit_idx = '0;
         if (md == MODE_RESET) begin
            s.phase = PH_RST_LOW;
            s.timer = span(c.reset_low);
         end else if (md == MODE_WRITE) begin
            s.shift = wd;
            s.phase = PH_WR_LOW;
            s.timer = bit_low_span(c, wd[0]);
         end else begin
            s.shift = '0;
            s.phase = PH_RD_LOW;
            s.timer = span(TIMER_W'(c.read_low));
         end
      end

      case (s.phase)
         PH_IDLE: ;
         PH_RST_LOW: begin
            o.res.drive_low = 1'b1;
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.phase = PH_RST_WAIT;
               s.timer = span(c.pres_wait);
            end
         end
         PH_RST_WAIT: begin
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.phase = PH_RST_POLL;
               s.timer = span(c.pres_timeout);
            end
         end
         // a low line while polling is the presence pulse
         PH_RST_POLL: begin
            if (!lvl) begin
               s.phase = PH_RST_REC;
               s.timer = span(c.reset_recover);
            end else begin
               s.timer = s.timer - TIMER_W'(1);
               if (s.timer == '0) begin
                  s.phase = PH_IDLE;
                  o.res.done_res = 1'b1;
                  o.res.presence_error = 1'b1;
               end
            end
         end
         PH_RST_REC: begin
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.phase = PH_IDLE;
               o.res.done_res = 1'b1;
               o.res.presence_found = 1'b1;
            end
         end
         PH_WR_LOW: begin
            o.res.drive_low = 1'b1;
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.phase = PH_WR_HIGH;
               s.timer = s.shift[0] ? span(TIMER_W'(c.write_long))
                                    : span(TIMER_W'(c.write_short));
            end
         end
         PH_WR_HIGH: begin
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.shift = s.shift >> 1;
               if (s.bit_idx == 3'd7) begin
                  s.bit_idx = '0;
                  s.phase = PH_IDLE;
                  o.res.done_res = 1'b1;
               end else begin
                  s.bit_idx = s.bit_idx + BIT_W'(1);
                  s.phase = PH_WR_LOW;
                  s.timer = bit_low_span(c, s.shift[0]);
               end
            end
         end
         PH_RD_LOW: begin
            o.res.drive_low = 1'b1;
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.phase = PH_RD_WAIT;
               s.timer = span(TIMER_W'(c.read_sample));
            end
         end
         PH_RD_WAIT: begin
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               s.phase = PH_RD_TAIL;
               s.timer = TAIL_TICKS;
            end
         end
         // sample on the first tail tick, LSB first
         PH_RD_TAIL: begin
            if (s.timer == TAIL_TICKS)
               s.shift = {lvl, s.shift[BYTE_W-1:1]};
            s.timer = s.timer - TIMER_W'(1);
            if (s.timer == '0) begin
               if (s.bit_idx == 3'd7) begin
                  s.bit_idx = '0;
                  s.phase = PH_IDLE;
                  o.res.done_res = 1'b1;
                  o.res.read_byte = s.shift;
               end else begin
                  s.bit_idx = s.bit_idx + BIT_W'(1);
                  s.phase = PH_RD_LOW;
                  s.timer = span(TIMER_W'(c.read_low));
               end
            end
         end
         default: s.phase = PH_IDLE;
      endcase

      o.res.busy_res = (s.phase != PH_IDLE);
      o.st = s;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want_v,
                              input logic [BYTE_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
         bad_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (tick_queue.size() != 0 &&
                      (req_odds == 0 || $urandom_range(1, req_odds) != 1)) begin
            next_tick = tick_queue.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.mode       <= next_tick.mode;
            req_bus.write_data <= next_tick.write_data;
            req_bus.bus_level  <= next_tick.bus_level;
         end else begin
            req_bus.valid <= 1'b0;
            if (tick_queue.size() != 0)
               req_gap <= $urandom_range(0, 3);
         end
      end
   end

   // result ready: short random stalls, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (want_long_stall && !long_stall_done) begin
         long_stall_done <= 1'b1;
         rsp_hold <= 300;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_odds != 0 && $urandom_range(1, rsp_odds) == 1) begin
         rsp_hold <= $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: check results, then predict for the request taken this edge
   always @(posedge clock) begin
      result_type got, want;
      line_step_type nx;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.drive_low        = rsp_bus.drive_low;
         got.busy_res         = rsp_bus.busy_res;
         got.done_res         = rsp_bus.done_res;
         got.presence_found   = rsp_bus.presence_found;
         got.presence_error   = rsp_bus.presence_error;
         got.read_byte        = rsp_bus.read_byte;
         got.command_rejected = rsp_bus.command_rejected;
         if (results_due.size() == 0) begin
            $display("%0t: result with no request outstanding, got %0h", $time, got);
            bad_count++;
         end else begin
            want = results_due.pop_front();
            check_field("drive_low", want.drive_low, got.drive_low);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("done_res", want.done_res, got.done_res);
            check_field("presence_found", want.presence_found, got.presence_found);
            check_field("presence_error", want.presence_error, got.presence_error);
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("command_rejected", want.command_rejected, got.command_rejected);
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         nx = step_master(line_state, live_cfg, req_bus.mode, req_bus.write_data,
                          req_bus.bus_level);
         line_state = nx.st;
         results_due.push_back(nx.res);
         accepted_count++;
      end
      if (!reset && csr_bus.valid && csr_bus.ready)
         live_cfg = store_reg(live_cfg, int'(csr_bus.index), csr_bus.data);
   end

   task automatic push_tick(input tick_req_type it);
      line_step_type nx;
      nx = step_master(plan_state, plan_cfg, it.mode, it.write_data, it.bus_level);
      plan_state = nx.st;
      tick_queue.push_back(it);
      queued_count++;
   endtask

   task automatic queue_idle(input int n);
      tick_req_type it;
      repeat (n) begin
         it.mode = MODE_TICK;
         it.write_data = BYTE_W'($urandom);
         it.bus_level = 1'($urandom);
         push_tick(it);
      end
   endtask

   // a command and its ticks up to done; answer_at is the polling tick at which
   // the device pulls low (-1: never), rd_bits what the device returns.
   // noise 1: random commands while busy, 2: a command on every done tick
   task automatic queue_command(input logic [MODE_W-1:0] md, input logic [BYTE_W-1:0] wd,
         input int answer_at, input logic [BYTE_W-1:0] rd_bits, input int noise);
      tick_req_type it;
      line_step_type look;
      int polled;
      polled = 0;
      it.mode = md;
      it.write_data = wd;
      it.bus_level = 1'($urandom);
      push_tick(it);
      while (plan_state.phase != PH_IDLE) begin
         it.mode = MODE_TICK;
         it.write_data = BYTE_W'($urandom);
         it.bus_level = 1'($urandom);
         if (plan_state.phase == PH_RST_POLL) begin
            it.bus_level = (polled != answer_at);
            polled++;
         end else if (plan_state.phase == PH_RD_TAIL && plan_state.timer == TAIL_TICKS) begin
            it.bus_level = rd_bits[plan_state.bit_idx];
         end
         if (noise != 0) begin
            look = step_master(plan_state, plan_cfg, it.mode, it.write_data, it.bus_level);
            if (look.res.done_res ? (noise == 2 || $urandom_range(0, 2) == 0)
                                  : (noise == 1 && $urandom_range(0, 29) == 0))
               it.mode = MODE_W'($urandom_range(MODE_RESET, MODE_READ));
         end
         push_tick(it);
      end
   endtask

   task automatic random_command();
      int window, answer_at, pick;
      logic [MODE_W-1:0] md;
      window = int'(span(plan_cfg.pres_timeout));
      case ($urandom_range(0, 3))
         0:       answer_at = -1;
         1:       answer_at = window - 1;
         default: answer_at = $urandom_range(0, window - 1);
      endcase
      pick = $urandom_range(0, 9);
      md = (pick < 4) ? MODE_RESET : (pick < 8) ? MODE_WRITE : MODE_READ;
      queue_command(md, BYTE_W'($urandom), answer_at, BYTE_W'($urandom), 1);
      queue_idle($urandom_range(0, 3));
   endtask

   task automatic write_reg(input int idx, input logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_IDX_W'(idx);
      csr_bus.data  <= d;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      plan_cfg = store_reg(plan_cfg, idx, d);
   endtask

   // mostly short timings so commands stay short; 8-bit registers get junk upper bits
   function automatic logic [CSR_DATA_W-1:0] random_timing(input int idx);
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = CSR_DATA_W'($urandom_range(7, 24));
         default: v = CSR_DATA_W'($urandom_range(1, 5));
      endcase
      if (idx >= REG_WRITE_SHORT)
         v[CSR_DATA_W-1:BYTE_W] = 2'($urandom_range(0, 3));
      return v;
   endfunction

   // wait until every queued tick is taken and every result checked
   task automatic drain();
      while (accepted_count != queued_count || results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #20000000;
      $display("end of test: mismatches");
      $finish;
   end

   // stimulus
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_TICK;
      req_bus.write_data = '0;
      req_bus.bus_level  = 1'b1;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_RESET_LOW;
      csr_bus.data       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default timings out of reset
      queue_idle(2);
      queue_command(MODE_WRITE, 8'hA5, -1, 8'h00, 1);
      drain();

      // every duration zero, which behaves as one tick
      for (int r = REG_RESET_LOW; r <= REG_READ_SAMPLE; r++)
         write_reg(r, '0);
      queue_command(MODE_RESET, 8'hFF, 0, 8'h00, 0);
      queue_command(MODE_RESET, 8'h00, -1, 8'h00, 2);
      queue_command(MODE_WRITE, 8'h00, -1, 8'h00, 0);
      queue_command(MODE_WRITE, 8'hFF, -1, 8'h00, 2);
      queue_idle(3);
      queue_command(MODE_READ, 8'hFF, -1, 8'h96, 2);
      queue_command(MODE_WRITE, 8'h3C, -1, 8'h00, 1);
      drain();

      // random timings and commands; the first batch also gets the long result stall
      while (queued_count < ITEM_TARGET - CLOSE_ITEMS) begin
         drain();
         for (int r = REG_RESET_LOW; r <= REG_READ_SAMPLE; r++)
            if ($urandom_range(0, 3) != 0)
               write_reg(r, random_timing(r));
         req_odds = 3 * $urandom_range(0, 2);
         rsp_odds = 3 * $urandom_range(0, 2);
         repeat (4) random_command();
         want_long_stall = 1'b1;
      end
      drain();

      // closing stretch at full rate
      req_odds = 0;
      rsp_odds = 0;
      while (queued_count < ITEM_TARGET)
         random_command();
      drain();

      if (bad_count == 0 && results_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
